// ===== rtl/core/ceq_pkg.sv =====
// Shared types and codes for the coalescing event queue.
// Used by ceq_ctrl, ceq_dp and coalescing_event_queue; depends on nothing.
package ceq_pkg;

  localparam logic OP_POST  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] event_id;
  } ceq_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [7:0]  event_out;
    logic [15:0] occurrences;
    logic        last;
  } ceq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic post_read;
    logic post_write;
    logic reject;
    logic drain_empty;
    logic drain_start;
    logic drain_issue;
    logic clear;
  } ceq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_drain;
    logic in_range;
    logic queue_empty;
    logic issue_last;
    logic drain_done;
  } ceq_sts_t;

endpackage

// ===== rtl/core/ceq_ctrl.sv =====
// Controller state machine of the coalescing event queue.
// Depends on ceq_pkg for the command and status structs.
module ceq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ceq_pkg::ceq_sts_t sts,
  output logic              busy,
  output ceq_pkg::ceq_cmd_t cmd
);
  import ceq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POST  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (sts.op_drain) begin
            if (sts.queue_empty) begin
              cmd.drain_empty = 1'b1;
              cmd.clear       = 1'b1;
            end else begin
              cmd.drain_start = 1'b1;
              state_next      = S_DRAIN;
            end
          end else if (sts.in_range) begin
            cmd.post_read = 1'b1;
            state_next    = S_POST;
          end else begin
            cmd.reject = 1'b1;
          end
        end
      end
      S_POST: begin
        cmd.post_write = 1'b1;
        state_next     = S_IDLE;
      end
      S_DRAIN: begin
        cmd.drain_issue = 1'b1;
        if (sts.issue_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // Wait for the last entry to leave the read pipeline.
        if (sts.drain_done) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ceq_dp.sv =====
// Datapath of the coalescing event queue: count memory with valid bits,
// order memory, queue length, drain read pipeline and result register.
// Depends on ceq_pkg for the payload, command and status structs.
module ceq_dp #(
  parameter int NUM_EVENTS = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  ceq_pkg::ceq_in_t  item,
  input  ceq_pkg::ceq_cmd_t cmd,
  output ceq_pkg::ceq_sts_t sts,
  output ceq_pkg::ceq_out_t result,
  output logic              strobe
);
  import ceq_pkg::*;

  localparam int IDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int LEN_W = $clog2(NUM_EVENTS + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Memories.
  logic [COUNT_BITS-1:0] cnt_mem [NUM_EVENTS];
  logic [IDX_W-1:0]      ord_mem [NUM_EVENTS];
  logic [NUM_EVENTS-1:0] valid;

  logic [LEN_W-1:0]      len;
  logic [IDX_W-1:0]      pos;
  logic [7:0]            ev_q;

  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  vld_rd;
  logic [IDX_W-1:0]      ord_rd;
  logic [IDX_W-1:0]      cnt_raddr;

  // Drain pipeline tags.
  logic                  v1;
  logic                  l1;
  logic                  v2;
  logic                  l2;
  logic [IDX_W-1:0]      e2;

  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  append;
  logic [31:0]           cnt_wide;
  logic [15:0]           occ_sat;

  assign sts.op_drain    = (item.opcode == OP_DRAIN);
  assign sts.in_range    = ({1'b0, item.event_id} < 9'(NUM_EVENTS));
  assign sts.queue_empty = (len == '0);
  assign sts.issue_last  = ((LEN_W'(pos) + LEN_W'(1)) == len);
  assign sts.drain_done  = v2 && l2;

  assign cnt_raddr = v1 ? ord_rd : item.event_id[IDX_W-1:0];

  // Post update: a count that is not valid reads as zero.
  assign cnt_cur = vld_rd ? cnt_rd : '0;
  assign cnt_new = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
  assign append  = (cnt_cur == '0) && (len < LEN_W'(NUM_EVENTS));

  assign cnt_wide = 32'(cnt_cur);
  assign occ_sat  = (cnt_wide > 32'hFFFF) ? 16'hFFFF : cnt_wide[15:0];

  always_ff @(posedge clk) begin
    if (cmd.post_write) begin
      cnt_mem[ev_q[IDX_W-1:0]] <= cnt_new;
    end
    cnt_rd <= cnt_mem[cnt_raddr];
    vld_rd <= valid[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.post_write && append) begin
      ord_mem[len[IDX_W-1:0]] <= ev_q[IDX_W-1:0];
    end
    ord_rd <= ord_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (cmd.post_read) begin
      ev_q <= item.event_id;
    end
    l1 <= sts.issue_last;
    l2 <= l1;
    e2 <= ord_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      len   <= '0;
      pos   <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      v1 <= cmd.drain_issue;
      v2 <= v1;
      if (cmd.drain_start) begin
        pos <= '0;
      end else if (cmd.drain_issue) begin
        pos <= pos + IDX_W'(1);
      end
      if (cmd.clear) begin
        valid <= '0;
        len   <= '0;
      end else if (cmd.post_write) begin
        valid[ev_q[IDX_W-1:0]] <= 1'b1;
        if (append) begin
          len <= len + LEN_W'(1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      result <= '{kind: KIND_ACK, status: STATUS_RANGE, event_out: item.event_id,
                  occurrences: 16'd0, last: 1'b1};
    end else if (cmd.post_write) begin
      result <= '{kind: KIND_ACK, status: STATUS_OK, event_out: ev_q,
                  occurrences: 16'd0, last: 1'b1};
    end else if (cmd.drain_empty) begin
      result <= '{kind: KIND_EMPTY, status: STATUS_OK, event_out: 8'd0,
                  occurrences: 16'd0, last: 1'b1};
    end else if (v2) begin
      result <= '{kind: KIND_ENTRY, status: STATUS_OK, event_out: 8'(e2),
                  occurrences: occ_sat, last: l2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.reject || cmd.post_write || cmd.drain_empty || v2;
    end
  end

endmodule

// ===== rtl/core/coalescing_event_queue.sv =====
// Coalescing event queue. An out-of-range post answers in the next cycle and leaves the block
// free; an in-range post holds it in S_POST, which writes its count back, and answers in the
// next cycle. A drain of a non-empty queue holds the block until its last entry has passed the
// two chained memory reads (order memory, then count memory), giving one beat a cycle; an
// empty drain answers in the next cycle. Results are strobed for one cycle; the receiver cannot
// stall. Reset (rst, synchronous) clears queue length and all count valid bits at once.
module coalescing_event_queue #(
  parameter int NUM_EVENTS = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ceq_pkg::ceq_in_t  item,
  output ceq_pkg::ceq_out_t result,
  output logic              strobe
);
  import ceq_pkg::*;

  // The controller sequences posts and drains; the datapath holds all storage.
  // Each in-range post reads the event's count, then writes it back incremented
  // (saturating), appending the event to the order memory on first arrival.
  // A drain walks the order memory, reads each queued event's count and emits
  // one beat per entry, flagging the final one, then clears every count by
  // dropping all valid bits at once.

  ceq_cmd_t cmd;
  ceq_sts_t sts;

  ceq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  ceq_dp #(
    .NUM_EVENTS (NUM_EVENTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result),
    .strobe (strobe)
  );

`ifndef NO_ASSERTIONS
  // An accepted post either keeps the block busy or answers in the next cycle.
  a_post_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.opcode == OP_POST) |=> (busy || strobe))
    else $error("post neither in progress nor answered");

  // A beat shown while the block is free must close its item.
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !busy) |-> result.last)
    else $error("non-final beat after block went idle");

  // Only a post acknowledgement can carry a range rejection.
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.kind != KIND_ACK) |-> (result.status == STATUS_OK))
    else $error("drain beat carries a rejection status");

  // A drain that finds work keeps the block busy in the next cycle.
  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.opcode == OP_DRAIN && !sts.queue_empty) |=> busy)
    else $error("drain of a non-empty queue did not occupy the block");
`endif

endmodule

// ===== tb/coalescing_event_queue_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the coalescing event queue: directed table, then random traffic.
// Depends on ceq_pkg and coalescing_event_queue; needs nothing else.
module coalescing_event_queue_tb;
  import ceq_pkg::*;

  localparam int NUM_EVENTS = 64;
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  // Most of a correct run's cycles go to the saturation phase.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 500;
  // The tail outlasts the time for which a full drain occupies the block.
  localparam int TAIL_CYCLES = NUM_EVENTS + 16;

  // One row of the directed table. Where typed is set, want is the result that must come back;
  // otherwise the result is taken from the predictor.
  typedef struct {
    ceq_in_t  cmd;
    bit       typed;
    ceq_out_t want;
  } row_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  ceq_in_t  item;
  ceq_out_t result;
  logic     strobe;

  // Typed expectation that travels with the beat on the item port. It is driven with
  // nonblocking assignments at the same edge as the item, so it lines up with acceptance.
  logic     row_typed;
  ceq_out_t row_want;

  // Predictor state: occurrence count per event number and the arrival order of queued events.
  logic [COUNT_BITS-1:0] occ_count [NUM_EVENTS];
  logic [5:0]            arrival [NUM_EVENTS];
  int unsigned           queued;

  ceq_out_t response_q [$];
  ceq_out_t awaited_q [$];
  row_t     directed_q [$];

  int mismatches;
  int cycle_count;
  int sent_items;
  int burst_left;

  coalescing_event_queue #(
    .NUM_EVENTS(NUM_EVENTS),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result(result),
    .strobe(strobe)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Prints one line per mismatch, up to a cap so a broken block cannot flood the log,
  // and counts every one of them.
  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  // Works out the result beats that one accepted beat causes and updates the predicted
  // state. A post answers with one acknowledgement; a drain walks the queue in arrival order
  // and then clears every count.
  task automatic queue_response(input ceq_in_t beat);
    ceq_out_t r;
    int unsigned e;
    response_q.delete();
    r = '0;
    r.last = 1'b1;
    if (beat.opcode == OP_POST) begin
      r.kind = KIND_ACK;
      r.event_out = beat.event_id;
      if (beat.event_id >= NUM_EVENTS) begin
        // Out-of-range posts are rejected and leave the state alone.
        r.status = STATUS_RANGE;
      end else begin
        // Only the first pending occurrence is queued; later ones just add to the count.
        if (occ_count[beat.event_id] == '0 && queued < NUM_EVENTS) begin
          arrival[queued] = beat.event_id[5:0];
          queued++;
        end
        // The count sticks at its maximum instead of wrapping back to zero.
        if (occ_count[beat.event_id] != COUNT_MAX) begin
          occ_count[beat.event_id] = occ_count[beat.event_id] + 1'b1;
        end
      end
      response_q.push_back(r);
    end else begin
      for (int pos = 0; pos < queued; pos++) begin
        e = 32'(arrival[pos]);
        r.kind = KIND_ENTRY;
        r.status = STATUS_OK;
        r.event_out = e[7:0];
        r.occurrences = occ_count[e];
        r.last = (pos == queued - 1);
        response_q.push_back(r);
      end
      // A drain that finds nothing queued still answers with a single empty beat.
      if (queued == 0) begin
        r.kind = KIND_EMPTY;
        response_q.push_back(r);
      end
      foreach (occ_count[i]) begin
        occ_count[i] = '0;
      end
      queued = 0;
    end
  endtask

  // Acceptance and checking. Everything is sampled at the rising edge, before the block's own
  // updates of that edge take effect, so the values seen belong to the cycle that just ended.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (awaited_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat kind %0d event %0d",
                                  result.kind, result.event_out));
      end else begin
        check_field("kind", int'(result.kind), int'(awaited_q[0].kind));
        check_field("status", int'(result.status), int'(awaited_q[0].status));
        check_field("event_out", int'(result.event_out), int'(awaited_q[0].event_out));
        check_field("occurrences", int'(result.occurrences),
                    int'(awaited_q[0].occurrences));
        check_field("last", int'(result.last), int'(awaited_q[0].last));
        void'(awaited_q.pop_front());
      end
    end
    if (!rst && start && !busy) begin
      queue_response(item);
      if (row_typed) begin
        awaited_q.push_back(row_want);
      end else begin
        foreach (response_q[i]) begin
          awaited_q.push_back(response_q[i]);
        end
      end
    end
  end

  // Watchdog: a block that stops answering ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // A post row carries its acknowledgement typed in, since it can be read off at a glance.
  function automatic row_t post_row(input logic [7:0] ev);
    row_t row;
    row.cmd.opcode = OP_POST;
    row.cmd.event_id = ev;
    row.typed = 1'b1;
    row.want.kind = KIND_ACK;
    row.want.status = (ev >= NUM_EVENTS) ? STATUS_RANGE : STATUS_OK;
    row.want.event_out = ev;
    row.want.occurrences = '0;
    row.want.last = 1'b1;
    return row;
  endfunction

  // A drain row is typed only where the queue is known to be empty.
  function automatic row_t drain_row(input logic [7:0] ev, input bit empty);
    row_t row;
    row.cmd.opcode = OP_DRAIN;
    row.cmd.event_id = ev;
    row.typed = empty;
    row.want.kind = KIND_EMPTY;
    row.want.status = STATUS_OK;
    row.want.event_out = '0;
    row.want.occurrences = '0;
    row.want.last = 1'b1;
    return row;
  endfunction

  // Presents one beat and holds it until the block takes it. Start stays high on return, so
  // a following beat can be presented at the very next edge without a bubble.
  task automatic drive_beat(input ceq_in_t beat, input bit typed, input ceq_out_t want);
    item <= beat;
    start <= 1'b1;
    row_typed <= typed;
    row_want <= want;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // Sender pacing: beats go out in bursts of random length, some bursts preceded by a gap.
  task automatic paced_beat(input ceq_in_t beat, input bit typed, input ceq_out_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    drive_beat(beat, typed, want);
    sent_items++;
  endtask

  task automatic post_beat(input logic [7:0] ev);
    ceq_in_t beat;
    beat.opcode = OP_POST;
    beat.event_id = ev;
    paced_beat(beat, 1'b0, '0);
  endtask

  task automatic drain_beat(input logic [7:0] ev);
    ceq_in_t beat;
    beat.opcode = OP_DRAIN;
    beat.event_id = ev;
    paced_beat(beat, 1'b0, '0);
  endtask

  // Holds the sender off until every expected beat has come back. The first edge lets the
  // monitor register a beat that was accepted at the edge this task was entered on.
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    ceq_in_t beat;
    int perm [NUM_EVENTS];
    int pick;
    int tmp;
    int choice;
    int len;
    int next_quiet;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    row_typed = 1'b0;
    row_want = '0;
    mismatches = 0;
    cycle_count = 0;
    sent_items = 0;
    burst_left = 0;
    queued = 0;
    foreach (occ_count[i]) begin
      occ_count[i] = '0;
      arrival[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty drain after reset, field extremes, rejected posts, repeated posts
    // that coalesce, drains with a nonzero ignored event number.
    directed_q.push_back(drain_row(8'h00, 1'b1));
    directed_q.push_back(post_row(8'd0));
    directed_q.push_back(post_row(8'd63));
    directed_q.push_back(post_row(8'd64));
    directed_q.push_back(post_row(8'd255));
    directed_q.push_back(post_row(8'd0));
    directed_q.push_back(post_row(8'hAA));
    directed_q.push_back(post_row(8'h55));
    directed_q.push_back(post_row(8'd21));
    directed_q.push_back(post_row(8'd42));
    directed_q.push_back(post_row(8'd63));
    directed_q.push_back(drain_row(8'hFF, 1'b0));
    directed_q.push_back(drain_row(8'h5A, 1'b1));
    directed_q.push_back(post_row(8'd1));
    directed_q.push_back(post_row(8'd1));
    directed_q.push_back(post_row(8'd1));
    directed_q.push_back(post_row(8'd2));
    directed_q.push_back(post_row(8'd128));
    directed_q.push_back(drain_row(8'h00, 1'b0));
    directed_q.push_back(drain_row(8'hFF, 1'b1));
    foreach (directed_q[i]) begin
      paced_beat(directed_q[i].cmd, directed_q[i].typed, directed_q[i].want);
    end
    wait_quiet();

    // Saturation: one event posted past the top of its count, back to back, alongside an
    // event with a single occurrence on each side of it in the queue order.
    beat.opcode = OP_POST;
    beat.event_id = 8'd7;
    drive_beat(beat, 1'b0, '0);
    beat.event_id = 8'd9;
    for (int k = 0; k < int'(COUNT_MAX) + 2; k++) begin
      drive_beat(beat, 1'b0, '0);
    end
    beat.event_id = 8'd11;
    drive_beat(beat, 1'b0, '0);
    beat.opcode = OP_DRAIN;
    beat.event_id = 8'd0;
    drive_beat(beat, 1'b0, '0);
    wait_quiet();

    // Random part. Most of it is post bursts closed by a drain; now and then every event is
    // posted in shuffled order so a drain returns the longest list, and some beats are lone
    // drains or lone posts of any event number, mostly out of range, as noise.
    sent_items = 0;
    next_quiet = 150;
    while (sent_items < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        foreach (perm[i]) begin
          perm[i] = i;
        end
        for (int i = NUM_EVENTS - 1; i > 0; i--) begin
          pick = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[pick];
          perm[pick] = tmp;
        end
        foreach (perm[i]) begin
          post_beat(perm[i][7:0]);
          if ($urandom_range(0, 3) == 0) begin
            post_beat(perm[$urandom_range(0, i)][7:0]);
          end
        end
        drain_beat(8'($urandom_range(0, 255)));
      end else if (choice <= 7) begin
        len = $urandom_range(1, 20);
        repeat (len) begin
          if ($urandom_range(0, 7) == 0) begin
            post_beat(8'($urandom_range(NUM_EVENTS, 255)));
          end else if ($urandom_range(0, 1) == 0) begin
            post_beat(8'($urandom_range(0, 7)));
          end else begin
            post_beat(8'($urandom_range(0, NUM_EVENTS - 1)));
          end
        end
        drain_beat(8'($urandom_range(0, 255)));
      end else if (choice == 8) begin
        drain_beat(8'($urandom_range(0, 255)));
      end else begin
        post_beat(8'($urandom_range(0, 255)));
      end
      if (sent_items >= next_quiet) begin
        wait_quiet();
        next_quiet += 150;
      end
    end
    drain_beat(8'd0);

    // Let every outstanding beat arrive, then watch a while longer for stray beats.
    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ceq_pkg.sv
rtl/core/ceq_ctrl.sv
rtl/core/ceq_dp.sv
rtl/core/coalescing_event_queue.sv
tb/coalescing_event_queue_tb.sv
